>>> src/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Types, constants and microcode shared by the point affine transform block.
// ----------------------------------------------------------------------------
package pat_pkg;

    typedef logic signed [31:0] coord_t;
    typedef coord_t [2:0]       coord3_t;
    typedef logic signed [31:0] coef_t;
    typedef coef_t [8:0]        mat_t;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam coef_t       ONE_Q30     = 32'sd1073741824;
    localparam coord_t      SCALE_RESET = 32'sd65536;
    localparam logic [3:0]  LAST_STEP   = 4'd13;

    typedef enum logic [2:0] {
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_SCALE_Z,
        REG_ROTATION
    } reg_index_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_TH,
        SQ_TH2,
        SQ_INIT,
        SQ_ACC,
        SQ_DLOAD,
        SQ_DIV,
        SQ_STORE,
        SQ_MP,
        SQ_MR
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_SX,
        OP_CX,
        OP_SY,
        OP_CY,
        OP_SZ,
        OP_CZ,
        OP_TMP
    } opnd_t;

    typedef enum logic [3:0] {
        D_M00,
        D_M01,
        D_M02,
        D_M10,
        D_M11,
        D_M12,
        D_M20,
        D_M21,
        D_M22,
        D_TMP
    } dest_t;

    typedef enum logic [1:0] {
        MO_SET,
        MO_NEG,
        MO_ADD,
        MO_SUB
    } mop_t;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
        dest_t dest;
        mop_t  op;
    } ucode_t;

    typedef struct packed {
        logic [5:0]  sh;
        logic [31:0] magic;
    } recip_t;

    // matrix products, one per step
    function automatic ucode_t pat_ucode(input logic [3:0] step);
        ucode_t u;
        unique case (step)
            4'd0:    u = '{OP_CY,  OP_CZ, D_M00, MO_SET};
            4'd1:    u = '{OP_CY,  OP_SZ, D_M01, MO_NEG};
            4'd2:    u = '{OP_CX,  OP_SZ, D_M10, MO_SET};
            4'd3:    u = '{OP_SX,  OP_SY, D_TMP, MO_SET};
            4'd4:    u = '{OP_TMP, OP_CZ, D_M10, MO_SUB};
            4'd5:    u = '{OP_CX,  OP_CZ, D_M11, MO_SET};
            4'd6:    u = '{OP_TMP, OP_SZ, D_M11, MO_ADD};
            4'd7:    u = '{OP_SX,  OP_CY, D_M12, MO_NEG};
            4'd8:    u = '{OP_SX,  OP_SZ, D_M20, MO_SET};
            4'd9:    u = '{OP_CX,  OP_SY, D_TMP, MO_SET};
            4'd10:   u = '{OP_TMP, OP_CZ, D_M20, MO_ADD};
            4'd11:   u = '{OP_SX,  OP_CZ, D_M21, MO_SET};
            4'd12:   u = '{OP_TMP, OP_SZ, D_M21, MO_SUB};
            default: u = '{OP_CX,  OP_CY, D_M22, MO_SET};
        endcase
        return u;
    endfunction

    // taylor term divisors as reciprocal multiplier and shift, exact below 2^31
    function automatic recip_t pat_recip(input logic cos_phase, input logic [2:0] k);
        recip_t rc;
        if (cos_phase)
        begin
            unique case (k)
                3'd0:    rc = '{6'd32, 32'd2147483648};
                3'd1:    rc = '{6'd35, 32'd2863311531};
                3'd2:    rc = '{6'd36, 32'd2290649225};
                3'd3:    rc = '{6'd37, 32'd2454267027};
                default: rc = '{6'd38, 32'd3054198967};
            endcase
        end
        else
        begin
            unique case (k)
                3'd0:    rc = '{6'd34, 32'd2863311531};
                3'd1:    rc = '{6'd36, 32'd3435973837};
                3'd2:    rc = '{6'd37, 32'd3272356036};
                default: rc = '{6'd38, 32'd3817748708};
            endcase
        end
        return rc;
    endfunction

endpackage

>>> src/pat_point_if.sv
// ----------------------------------------------------------------------------
// pat_point_if
// Input channel: one point per item.
// ----------------------------------------------------------------------------
interface pat_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

>>> src/pat_result_if.sv
// ----------------------------------------------------------------------------
// pat_result_if
// Output channel: one transformed point per item.
// ----------------------------------------------------------------------------
interface pat_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               overflow;

    modport source (output valid, output result_x, output result_y, output result_z,
                    output overflow, input ready);
    modport sink   (input valid, input result_x, input result_y, input result_z,
                    input overflow, output ready);
endinterface

>>> src/pat_matrix.sv
// ----------------------------------------------------------------------------
// pat_matrix
// Sequencer that forms sin/cos of the three angles by taylor series and
// composes the rotation matrix with one shared multiplier.
// ----------------------------------------------------------------------------
module pat_matrix #(
    parameter int ANGLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [47:0]   angles,
    output logic          busy,
    output pat_pkg::mat_t matrix
);
    import pat_pkg::*;

    localparam logic [15:0] CODE_MASK = 16'hFFFF << (16 - ANGLE_BITS);

    seq_state_t  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    logic [3:0]  step_reg, step_next;
    logic [2:0]  k_reg, k_next;
    logic        cos_reg, cos_next;
    logic        fold_reg, fold_next;
    logic [1:0]  quad_reg, quad_next;
    logic [13:0] t_reg, t_next;
    logic [29:0] th_reg, th_next;
    logic [29:0] th2_reg, th2_next;
    logic [31:0] term_reg, term_next;
    coef_t       acc_reg, acc_next;
    coef_t       sn_reg, sn_next;
    logic [63:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    coef_t       sx_reg, sx_next, cx_reg, cx_next;
    coef_t       sy_reg, sy_next, cy_reg, cy_next;
    coef_t       sz_reg, sz_next, cz_reg, cz_next;
    coef_t       tmp_reg, tmp_next;
    mat_t        m_reg, m_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] product;
    logic [15:0] code;
    logic [13:0] r;
    logic        fold_c;
    logic [29:0] th_c;
    coef_t       acc_sum;
    logic        last_term;
    recip_t      rc;
    coef_t       sv, cv, s_q, c_q;
    ucode_t      uc;
    coef_t       opa, opb, res;
    logic [63:0] rnd;

    function automatic coef_t pick(input opnd_t o, input coef_t sx, input coef_t cx,
                                   input coef_t sy, input coef_t cy, input coef_t sz,
                                   input coef_t cz, input coef_t tm);
        coef_t v;
        unique case (o)
            OP_SX:   v = sx;
            OP_CX:   v = cx;
            OP_SY:   v = sy;
            OP_CY:   v = cy;
            OP_SZ:   v = sz;
            OP_CZ:   v = cz;
            default: v = tm;
        endcase
        return v;
    endfunction

    assign product = mul_a * mul_b;
    assign busy    = (state_reg != SQ_IDLE);
    assign matrix  = m_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        cos_next   = cos_reg;
        fold_next  = fold_reg;
        quad_next  = quad_reg;
        t_next     = t_reg;
        th_next    = th_reg;
        th2_next   = th2_reg;
        term_next  = term_reg;
        acc_next   = acc_reg;
        sn_next    = sn_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        sx_next    = sx_reg;
        cx_next    = cx_reg;
        sy_next    = sy_reg;
        cy_next    = cy_reg;
        sz_next    = sz_reg;
        cz_next    = cz_reg;
        tmp_next   = tmp_reg;
        m_next     = m_reg;
        mul_a      = term_reg;
        mul_b      = {2'b00, th2_reg};

        unique case (axis_reg)
            2'd0:    code = angles[15:0] & CODE_MASK;
            2'd1:    code = angles[31:16] & CODE_MASK;
            default: code = angles[47:32] & CODE_MASK;
        endcase
        r      = code[13:0];
        fold_c = (r > 14'd8192);
        th_c   = prod_reg[44:15];

        acc_sum   = k_reg[0] ? acc_reg - coef_t'(term_reg) : acc_reg + coef_t'(term_reg);
        last_term = cos_reg ? (k_reg == 3'd5) : (k_reg == 3'd4);

        rc = pat_recip(cos_reg, k_reg);

        sv = fold_reg ? acc_reg : sn_reg;
        cv = fold_reg ? sn_reg : acc_reg;
        unique case (quad_reg)
            2'd0:    begin s_q = sv;  c_q = cv;  end
            2'd1:    begin s_q = cv;  c_q = -sv; end
            2'd2:    begin s_q = -sv; c_q = -cv; end
            default: begin s_q = -cv; c_q = sv;  end
        endcase

        uc  = pat_ucode(step_reg);
        opa = pick(uc.a, sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg, tmp_reg);
        opb = pick(uc.b, sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg, tmp_reg);
        rnd = prod_reg + 64'd536870912;
        res = neg_reg ? -coef_t'(rnd[61:30]) : coef_t'(rnd[61:30]);

        unique case (state_reg)
            SQ_IDLE:
            begin
            end
            SQ_LOAD:
            begin
                quad_next  = code[15:14];
                fold_next  = fold_c;
                t_next     = fold_c ? 14'(15'd16384 - {1'b0, r}) : r;
                state_next = SQ_TH;
            end
            SQ_TH:
            begin
                mul_a      = {18'd0, t_reg};
                mul_b      = PI_Q30;
                prod_next  = product;
                state_next = SQ_TH2;
            end
            SQ_TH2:
            begin
                mul_a      = {2'b00, th_c};
                mul_b      = {2'b00, th_c};
                th_next    = th_c;
                prod_next  = product;
                state_next = SQ_INIT;
            end
            SQ_INIT:
            begin
                th2_next   = prod_reg[59:30];
                term_next  = {2'b00, th_reg};
                acc_next   = '0;
                k_next     = '0;
                cos_next   = 1'b0;
                state_next = SQ_ACC;
            end
            SQ_ACC:
            begin
                if (last_term)
                begin
                    if (!cos_reg)
                    begin
                        sn_next   = acc_sum;
                        acc_next  = '0;
                        term_next = 32'(ONE_Q30);
                        k_next    = '0;
                        cos_next  = 1'b1;
                    end
                    else
                    begin
                        acc_next   = acc_sum;
                        state_next = SQ_STORE;
                    end
                end
                else
                begin
                    acc_next   = acc_sum;
                    prod_next  = product;
                    state_next = SQ_DLOAD;
                end
            end
            SQ_DLOAD:
            begin
                mul_a      = prod_reg[61:30];
                mul_b      = rc.magic;
                prod_next  = product;
                state_next = SQ_DIV;
            end
            SQ_DIV:
            begin
                term_next  = 32'(prod_reg >> rc.sh);
                k_next     = k_reg + 3'd1;
                state_next = SQ_ACC;
            end
            SQ_STORE:
            begin
                unique case (axis_reg)
                    2'd0:    begin sx_next = s_q; cx_next = c_q; end
                    2'd1:    begin sy_next = s_q; cy_next = c_q; end
                    default: begin sz_next = s_q; cz_next = c_q; end
                endcase
                if (axis_reg == 2'd2)
                begin
                    step_next  = '0;
                    state_next = SQ_MP;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = SQ_LOAD;
                end
            end
            SQ_MP:
            begin
                mul_a      = opa[31] ? 32'(-opa) : 32'(opa);
                mul_b      = opb[31] ? 32'(-opb) : 32'(opb);
                prod_next  = product;
                neg_next   = opa[31] ^ opb[31];
                state_next = SQ_MR;
            end
            SQ_MR:
            begin
                if (uc.dest == D_TMP)
                begin
                    tmp_next = res;
                end
                else
                begin
                    unique case (uc.op)
                        MO_SET:  m_next[uc.dest] = res;
                        MO_NEG:  m_next[uc.dest] = -res;
                        MO_ADD:  m_next[uc.dest] = m_reg[uc.dest] + res;
                        default: m_next[uc.dest] = m_reg[uc.dest] - res;
                    endcase
                end
                if (step_reg == LAST_STEP)
                begin
                    m_next[D_M02] = -sy_reg;
                    state_next    = SQ_IDLE;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = SQ_MP;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase

        if (start)
        begin
            axis_next  = '0;
            state_next = SQ_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
            cos_reg   <= 1'b0;
            m_reg     <= '{D_M00: ONE_Q30, D_M11: ONE_Q30, D_M22: ONE_Q30, default: '0};
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            cos_reg   <= cos_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
        quad_reg <= quad_next;
        t_reg    <= t_next;
        th_reg   <= th_next;
        th2_reg  <= th2_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        sn_reg   <= sn_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        sx_reg   <= sx_next;
        cx_reg   <= cx_next;
        sy_reg   <= sy_next;
        cy_reg   <= cy_next;
        sz_reg   <= sz_next;
        cz_reg   <= cz_next;
        tmp_reg  <= tmp_next;
    end

endmodule

>>> src/pat_datapath.sv
// ----------------------------------------------------------------------------
// pat_datapath
// Six stage point pipeline: translate, multiply, round, sum and clamp,
// scale, round and saturate.
// ----------------------------------------------------------------------------
module pat_datapath #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             hold,
    input  pat_pkg::coord3_t offset,
    input  pat_pkg::coord3_t scale,
    input  pat_pkg::mat_t    matrix,
    pat_point_if.sink        point,
    pat_result_if.source     result
);
    import pat_pkg::*;

    localparam logic [65:0] HALF = 66'd1 << (COORD_FRAC_BITS - 1);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                     rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic signed [32:0]       s1_reg [3];
    logic [63:0]              s2_reg [9];
    logic                     n2_reg [9];
    logic signed [35:0]       s3_reg [9];
    logic [32:0]              s4_reg [3];
    logic                     n4_reg [3];
    logic [64:0]              s5_reg [3];
    logic                     n5_reg [3];
    coord_t                   res_reg [3];
    logic                     ovf_reg;

    coord_t                   pt [3];
    logic signed [32:0]       s1_next [3];
    logic [63:0]              s2_next [9];
    logic                     n2_next [9];
    logic signed [35:0]       s3_next [9];
    logic [32:0]              s4_next [3];
    logic                     n4_next [3];
    logic [64:0]              s5_next [3];
    coord_t                   res_next [3];
    logic [2:0]               sat;

    assign rdy6 = !v6_reg || result.ready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign point.ready = rdy1 && !hold;

    assign pt[0] = point.point_x;
    assign pt[1] = point.point_y;
    assign pt[2] = point.point_z;

    always_comb
    begin
        logic [31:0]        am;
        logic [32:0]        vm;
        logic [63:0]        rs;
        logic signed [37:0] rot;
        logic [37:0]        ra;
        logic [31:0]        sm;
        logic [65:0]        q;
        for (int i = 0; i < 3; i++)
        begin
            s1_next[i] = 33'(pt[i]) + 33'(offset[i]);
        end
        for (int k = 0; k < 9; k++)
        begin
            am = matrix[k][31] ? 32'(-matrix[k]) : 32'(matrix[k]);
            vm = s1_reg[k % 3][32] ? 33'(-s1_reg[k % 3]) : 33'(s1_reg[k % 3]);
            s2_next[k] = {32'd0, am} * {31'd0, vm};
            n2_next[k] = matrix[k][31] ^ s1_reg[k % 3][32];
            rs = s2_reg[k] + 64'd536870912;
            s3_next[k] = n2_reg[k] ? -$signed({2'b00, rs[63:30]}) : $signed({2'b00, rs[63:30]});
        end
        for (int i = 0; i < 3; i++)
        begin
            rot = 38'(s3_reg[3 * i]) + 38'(s3_reg[3 * i + 1]) + 38'(s3_reg[3 * i + 2]);
            ra  = rot[37] ? 38'(-rot) : 38'(rot);
            s4_next[i] = (ra > 38'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : ra[32:0];
            n4_next[i] = rot[37] ^ scale[i][31];
            sm = scale[i][31] ? 32'(-scale[i]) : 32'(scale[i]);
            s5_next[i] = {32'd0, s4_reg[i]} * {33'd0, sm};
            q = ({1'b0, s5_reg[i]} + HALF) >> COORD_FRAC_BITS;
            if (!n5_reg[i] && q > 66'd2147483647)
            begin
                res_next[i] = 32'sh7FFF_FFFF;
                sat[i]      = 1'b1;
            end
            else if (n5_reg[i] && q > 66'd2147483648)
            begin
                res_next[i] = 32'sh8000_0000;
                sat[i]      = 1'b1;
            end
            else
            begin
                res_next[i] = n5_reg[i] ? -coord_t'(q[31:0]) : coord_t'(q[31:0]);
                sat[i]      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= point.valid && point.ready;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2)
        begin
            s2_reg <= s2_next;
            n2_reg <= n2_next;
        end
        if (rdy3) s3_reg <= s3_next;
        if (rdy4)
        begin
            s4_reg <= s4_next;
            n4_reg <= n4_next;
        end
        if (rdy5)
        begin
            s5_reg <= s5_next;
            n5_reg <= n4_reg;
        end
        if (rdy6)
        begin
            res_reg <= res_next;
            ovf_reg <= |sat;
        end
    end

    assign result.valid    = v6_reg;
    assign result.result_x = res_reg[0];
    assign result.result_y = res_reg[1];
    assign result.result_z = res_reg[2];
    assign result.overflow = ovf_reg;

endmodule

>>> src/point_affine_transform.sv
// ----------------------------------------------------------------------------
// point_affine_transform
// Translates, rotates (euler x, y, z) and scales signed fixed point points.
//
// Points enter on the point channel and leave on the result channel, both
// valid/ready; an item moves when valid and ready are high at a clock edge.
// The pipeline takes one point per cycle unless held by the matrix sequencer or
// by back pressure; a result is valid once its point has passed every stage
// register. Stage valid bits let bubbles close up, so a stalled receiver holds
// results in place and back pressure reaches the input only once every stage
// is full. Registers must be written through wr_en / wr_index / wr_data only
// while no point is in flight; the block does not enforce it. A write to the
// rotation register starts the matrix sequencer, which forms sin and cos by
// taylor series on one shared multiplier, dividing each term by a reciprocal
// multiply, then the nine matrix entries; point.ready stays low from the
// write cycle until it is done.
// Reset clears the pipeline, loads the register defaults and the identity
// matrix, so points are taken right after reset.
// ----------------------------------------------------------------------------
module point_affine_transform #(
    parameter int ANGLE_BITS      = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [2:0]   wr_index,
    input  logic [47:0]  wr_data,
    pat_point_if.sink    point,
    pat_result_if.source result
);
    import pat_pkg::*;

    coord3_t     off_reg;
    coord3_t     scl_reg;
    logic [47:0] ang_reg;
    logic        start;
    logic        busy;
    mat_t        matrix;

    assign start = wr_en && (reg_index_t'(wr_index) == REG_ROTATION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            scl_reg <= {SCALE_RESET, SCALE_RESET, SCALE_RESET};
            ang_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_OFFSET_X: off_reg[0] <= wr_data[31:0];
                REG_OFFSET_Y: off_reg[1] <= wr_data[31:0];
                REG_OFFSET_Z: off_reg[2] <= wr_data[31:0];
                REG_SCALE_X:  scl_reg[0] <= wr_data[31:0];
                REG_SCALE_Y:  scl_reg[1] <= wr_data[31:0];
                REG_SCALE_Z:  scl_reg[2] <= wr_data[31:0];
                REG_ROTATION: ang_reg    <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    pat_matrix #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .angles (ang_reg),
        .busy   (busy),
        .matrix (matrix)
    );

    pat_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .hold   (busy || start),
        .offset (off_reg),
        .scale  (scl_reg),
        .matrix (matrix),
        .point  (point),
        .result (result)
    );

endmodule
